// ----- sv/drps_pkg.sv -----
// Package for the dual ranger poll sequencer: the poll phases, sequencer states,
// configuration register indexes, field widths and reset values.
// It has no dependencies. The top level imports it.
`default_nettype none

package drps_pkg;

  // Number of rangefinders that are polled in turn. The index width is fixed at one bit.
  localparam int NUM_SENSORS = 2;

  // Widths of the fields.
  localparam int RAW_W     = 16;
  localparam int GAIN_W    = 16;
  localparam int OFFSET_W  = 20;
  localparam int WEIGHT_W  = 9;
  localparam int LIMIT_W   = 8;
  localparam int DIST_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;

  // Serial arithmetic: one multiplier bit per cycle.
  localparam int ACC_W        = 33;
  localparam int MCAND_W      = 32;
  localparam int MD_W         = 26;
  localparam int CNT_W        = 4;
  localparam int CAL_STEPS    = 16;
  localparam int SMOOTH_STEPS = 9;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]   GAIN_RST    = 16'd64225;
  localparam logic [OFFSET_W-1:0] OFFSET_RST  = 20'd425984;
  localparam logic [RAW_W-1:0]    LOW_RST     = 16'd10;
  localparam logic [RAW_W-1:0]    HIGH_RST    = 16'd500;
  localparam logic [WEIGHT_W-1:0] KEEP_RST    = 9'd51;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST   = 8'd30;
  localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;
  localparam logic [DIST_W-1:0]   DIST_MAX    = 17'h1FFFF;

  // Bus phases of one sensor poll.
  typedef enum logic [1:0] {
    PH_SELECT  = 2'd0,
    PH_TRIGGER = 2'd1,
    PH_ADDRESS = 2'd2,
    PH_READ    = 2'd3
  } phase_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL,
    ST_CHECK,
    ST_SMOOTH,
    ST_EMIT
  } seq_state_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_GAIN      = 3'd0,
    CFG_CAL_OFFSET    = 3'd1,
    CFG_RANGE_LOW     = 3'd2,
    CFG_RANGE_HIGH    = 3'd3,
    CFG_KEEP_WEIGHT   = 3'd4,
    CFG_TIMEOUT_LIMIT = 3'd5
  } cfg_index_t;

endpackage

`default_nettype wire

// ----- sv/dual_ranger_poll_sequencer.sv -----
// Top level of the dual ranger poll sequencer: the phase sequencer, the serial
// calibration multiplier and the serial smoothing unit, all in one module.
// Depends on drps_pkg.
//
//  Channel  Direction  Signals                         Contents
//  s_*      in         s_tvalid s_tready s_tdata[23:0] one poll step request
//  m_*      out        m_tvalid m_tready m_tdata[23:0] one step result
//  cfg_*    in         cfg_we cfg_addr cfg_data        configuration writes
//
// From the accepting edge, select, trigger, address and failed read steps go
// straight to the emit state and then into the output register. A successful
// read of sensor 1 passes through the check state first; for sensor 0 the
// shift-add calibration multiplier runs in the calibration state before it, and
// a reading inside the window adds a pass through the shift-add smoothing state.
// Only one step is in flight. A new request is taken while the last result
// still waits in the output register; a stalled output holds the next step in
// the emit state and the input waits with it. Reset is synchronous, holds the
// input off and clears the phase, the failure count, the enable lines and both
// stored distances.
`default_nettype none

module dual_ranger_poll_sequencer
  import drps_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst,
  // s_tdata: bus_ok[0], raw_range[16:1], zero[23:17]
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire  [IN_W-1:0]      s_tdata,
  // m_tdata: action[1:0], sensor[2], enable_mask[4:3], updated[5],
  //          timed_out[6], distance[23:7]
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [OUT_W-1:0]     m_tdata,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_addr,
  input  wire  [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [GAIN_W-1:0]   cal_gain;
  logic [OFFSET_W-1:0] cal_offset;
  logic [RAW_W-1:0]    range_low;
  logic [RAW_W-1:0]    range_high;
  logic [WEIGHT_W-1:0] keep_weight;
  logic [LIMIT_W-1:0]  timeout_limit;

  // Control state.
  seq_state_t          state, state_next;
  phase_t              phase;
  logic                active_sensor;
  logic [LIMIT_W-1:0]  fail_count;
  logic [1:0]          enable_lines;
  logic [DIST_W-1:0]   stored_dist [NUM_SENSORS];

  // Step working registers.
  logic                in_ok;
  logic                in_win;
  logic [ACC_W-1:0]    acc;
  logic [MCAND_W-1:0]  mcand;
  logic [RAW_W-1:0]    mplier;
  logic [MD_W-1:0]     md;
  logic [WEIGHT_W-1:0] kk;
  logic [WEIGHT_W-1:0] ww;
  logic [CNT_W-1:0]    cnt;

  // Handshake strobes.
  logic                accept;
  logic                emit_fire;
  logic                start_read;

  // Combinational step results.
  logic [RAW_W-1:0]    cal_val;
  logic                win;
  logic [WEIGHT_W-1:0] k_sat;
  logic [DIST_W-1:0]   cap;
  logic [DIST_W-1:0]   d_new;
  phase_t              phase_next;
  logic                sensor_next;
  logic [LIMIT_W-1:0]  fail_next;
  logic [1:0]          enable_next;
  logic                upd;
  logic                tmo;
  logic [DIST_W-1:0]   dist_out;

  assign s_tready   = (state == ST_IDLE) && !rst;
  assign accept     = s_tvalid && s_tready;
  assign emit_fire  = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign start_read = (phase == PH_READ) && s_tdata[0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_gain      <= GAIN_RST;
      cal_offset    <= OFFSET_RST;
      range_low     <= LOW_RST;
      range_high    <= HIGH_RST;
      keep_weight   <= KEEP_RST;
      timeout_limit <= LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CAL_GAIN:      cal_gain      <= cfg_data[GAIN_W-1:0];
        CFG_CAL_OFFSET:    cal_offset    <= cfg_data[OFFSET_W-1:0];
        CFG_RANGE_LOW:     range_low     <= cfg_data[RAW_W-1:0];
        CFG_RANGE_HIGH:    range_high    <= cfg_data[RAW_W-1:0];
        CFG_KEEP_WEIGHT:   keep_weight   <= cfg_data[WEIGHT_W-1:0];
        CFG_TIMEOUT_LIMIT: timeout_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Calibrated reading, saturated to 16 bits, and the window test.
  assign cal_val = acc[ACC_W-1] ? {RAW_W{1'b1}} : acc[ACC_W-2:RAW_W];
  assign win     = (cal_val > range_low) && (cal_val < range_high);
  assign k_sat   = (keep_weight > WEIGHT_FULL) ? WEIGHT_FULL : keep_weight;

  // Smoothed distance, capped at range_high in Q8 and at the field maximum.
  always_comb begin
    if (range_high[RAW_W-1:DIST_W-8] != '0) begin
      cap = DIST_MAX;
    end else begin
      cap = {range_high[DIST_W-9:0], 8'd0};
    end
    if (acc[ACC_W-1:8] > {8'd0, cap}) begin
      d_new = cap;
    end else begin
      d_new = acc[DIST_W+7:8];
    end
  end

  // Phase, sensor, failure count and enable lines after the step.
  always_comb begin
    phase_next  = phase;
    sensor_next = active_sensor;
    fail_next   = fail_count;
    enable_next = enable_lines;
    upd         = 1'b0;
    tmo         = 1'b0;
    case (phase)
      PH_SELECT: begin
        enable_next = active_sensor ? 2'b10 : 2'b01;
        phase_next  = PH_TRIGGER;
        fail_next   = '0;
      end
      PH_TRIGGER, PH_ADDRESS: begin
        if (in_ok) begin
          phase_next = phase_t'(phase + 2'd1);
        end else if (fail_count != {LIMIT_W{1'b1}}) begin
          fail_next = fail_count + LIMIT_W'(1);
        end
      end
      PH_READ: begin
        if (in_ok) begin
          upd         = in_win;
          sensor_next = ~active_sensor;
          phase_next  = PH_SELECT;
        end else if (fail_count != {LIMIT_W{1'b1}}) begin
          fail_next = fail_count + LIMIT_W'(1);
        end
      end
      default: ;
    endcase
    if (fail_next > timeout_limit) begin
      phase_next  = PH_SELECT;
      sensor_next = ~sensor_next;
      fail_next   = '0;
      tmo         = 1'b1;
    end
    dist_out = upd ? d_new : stored_dist[active_sensor];
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (start_read) begin
            state_next = active_sensor ? ST_CHECK : ST_CAL;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_CAL: begin
        if (cnt == CNT_W'(CAL_STEPS - 1)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = win ? ST_SMOOTH : ST_EMIT;
      end
      ST_SMOOTH: begin
        if (cnt == CNT_W'(SMOOTH_STEPS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Serial datapath: shift-add calibration, then shift-add smoothing.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          in_ok  <= s_tdata[0];
          in_win <= 1'b0;
          cnt    <= '0;
          mcand  <= {{(MCAND_W-GAIN_W){1'b0}}, cal_gain};
          mplier <= s_tdata[RAW_W:1];
          if (active_sensor) begin
            acc <= {1'b0, s_tdata[RAW_W:1], {RAW_W{1'b0}}};
          end else begin
            acc <= {{(ACC_W-OFFSET_W){1'b0}}, cal_offset};
          end
        end
      end
      ST_CAL: begin
        if (mplier[0]) begin
          acc <= acc + {1'b0, mcand};
        end
        mcand  <= {mcand[MCAND_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[RAW_W-1:1]};
        cnt    <= cnt + CNT_W'(1);
      end
      ST_CHECK: begin
        in_win <= win;
        acc    <= '0;
        cnt    <= '0;
        md     <= {{(MD_W-DIST_W){1'b0}}, stored_dist[active_sensor]};
        mcand  <= {8'd0, cal_val, 8'd0};
        kk     <= k_sat;
        ww     <= WEIGHT_FULL - k_sat;
      end
      ST_SMOOTH: begin
        acc <= acc + (kk[0] ? {{(ACC_W-MD_W){1'b0}}, md} : '0)
                   + (ww[0] ? {1'b0, mcand} : '0);
        md    <= {md[MD_W-2:0], 1'b0};
        mcand <= {mcand[MCAND_W-2:0], 1'b0};
        kk    <= {1'b0, kk[WEIGHT_W-1:1]};
        ww    <= {1'b0, ww[WEIGHT_W-1:1]};
        cnt   <= cnt + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // Poll state and stored distances are committed as the result is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SELECT;
      active_sensor  <= 1'b0;
      fail_count     <= '0;
      enable_lines   <= '0;
      stored_dist[0] <= '0;
      stored_dist[1] <= '0;
    end else if (emit_fire) begin
      phase         <= phase_next;
      active_sensor <= sensor_next;
      fail_count    <= fail_next;
      enable_lines  <= enable_next;
      if (upd) begin
        stored_dist[active_sensor] <= d_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {dist_out, tmo, upd, enable_next, active_sensor, phase};
    end
  end

`ifndef SYNTHESIS
  // A new result only ever comes from the emit state.
  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_EMIT))
    else $error("result raised outside the emit state");

  // At most one sensor is enabled at any time.
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(enable_lines))
    else $error("more than one enable line driven");

  // A timeout returns the sequencer to select with a cleared count.
  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    (emit_fire && tmo) |=> (phase == PH_SELECT && fail_count == '0))
    else $error("timeout did not return to select");

  // A window hit is only recorded while serving a read.
  a_win_in_read: assert property (@(posedge clk) disable iff (rst)
    (in_win && state != ST_IDLE) |-> (phase == PH_READ && in_ok))
    else $error("window flag outside a successful read");

  // The smoothing unit is only entered from a successful read.
  a_smooth_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SMOOTH && $past(state) == ST_CHECK) |-> (phase == PH_READ))
    else $error("smoothing started outside the read phase");
`endif

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the dual ranger poll sequencer: drives poll step requests,
// predicts every result with its own model of the phases, calibration and smoothing.
// Depends on drps_pkg and dual_ranger_poll_sequencer.
`default_nettype none

module testbench;
  import drps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int MAX_REPORTS   = 40;

  // One result as it sits in m_tdata, lowest field last.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              timed_out;
    logic              updated;
    logic [1:0]        enable_mask;
    logic              sensor;
    logic [1:0]        action;
  } step_result_t;

  // One full register setting.
  typedef struct {
    logic [GAIN_W-1:0]   gain;
    logic [OFFSET_W-1:0] offset;
    logic [RAW_W-1:0]    lo_bound;
    logic [RAW_W-1:0]    hi_bound;
    logic [WEIGHT_W-1:0] keep;
    logic [LIMIT_W-1:0]  limit;
  } ranger_cfg_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predicted state of the sequencer.
  ranger_cfg_t       cfg_now;
  phase_t            poll_phase;
  logic              cur_sensor;
  logic [7:0]        fail_cnt;
  logic [1:0]        enable_lines;
  logic [DIST_W-1:0] avg_dist [NUM_SENSORS];

  step_result_t expected_steps [$];
  step_result_t got_step, want_step;

  int  errors = 0;
  int  steps_sent = 0;
  int  updates_seen = 0;
  int  timeouts_seen = 0;
  int  settings_applied = 0;
  int  cycle_cnt = 0;
  int  hold_asks = 0;
  int  hold_taken = 0;
  int  hold_left = 0;
  bit  idle_on = 1'b1;

  dual_ranger_poll_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Works out the result of one poll step and advances the predicted state.
  function automatic step_result_t poll_step(input logic ok, input logic [RAW_W-1:0] raw);
    step_result_t r;
    logic [63:0]  cal;
    logic [63:0]  acc;
    logic [63:0]  cap;
    logic [8:0]   k;
    r = '0;
    r.action = poll_phase;
    r.sensor = cur_sensor;
    case (poll_phase)
      PH_SELECT: begin
        enable_lines = 2'b01 << cur_sensor;
        poll_phase = PH_TRIGGER;
        fail_cnt = '0;
      end
      PH_TRIGGER, PH_ADDRESS: begin
        if (ok) begin
          poll_phase = phase_t'(poll_phase + 2'd1);
        end else if (fail_cnt != 8'hFF) begin
          fail_cnt = fail_cnt + 8'd1;
        end
      end
      default: begin
        if (ok) begin
          // Sensor zero is calibrated, sensor one is taken as read.
          if (cur_sensor == 1'b0) begin
            cal = (64'(raw) * 64'(cfg_now.gain) + 64'(cfg_now.offset)) >> 16;
            if (cal > 64'd65535) cal = 64'd65535;
          end else begin
            cal = 64'(raw);
          end
          if (cal < 64'(cfg_now.hi_bound) && cal > 64'(cfg_now.lo_bound)) begin
            k = (cfg_now.keep > WEIGHT_FULL) ? WEIGHT_FULL : cfg_now.keep;
            acc = 64'(k) * 64'(avg_dist[cur_sensor]) + 64'(9'd256 - k) * cal * 64'd256;
            acc = acc >> 8;
            cap = 64'(cfg_now.hi_bound) * 64'd256;
            if (cap > 64'(DIST_MAX)) cap = 64'(DIST_MAX);
            if (acc > cap) acc = cap;
            avg_dist[cur_sensor] = acc[DIST_W-1:0];
            r.updated = 1'b1;
          end
          cur_sensor = ~cur_sensor;
          poll_phase = PH_SELECT;
        end else if (fail_cnt != 8'hFF) begin
          fail_cnt = fail_cnt + 8'd1;
        end
      end
    endcase
    // Too many failures: back to select on the other sensor.
    if (fail_cnt > cfg_now.limit) begin
      poll_phase = PH_SELECT;
      cur_sensor = ~cur_sensor;
      fail_cnt = '0;
      r.timed_out = 1'b1;
    end
    r.enable_mask = enable_lines;
    r.distance = avg_dist[r.sensor];
    return r;
  endfunction

  // Sends one poll step request, with a random gap in front of it.
  task automatic send_step(input logic ok, input logic [RAW_W-1:0] raw);
    if (idle_on && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, raw, ok};
    do @(posedge clk); while (!s_tready);
    expected_steps.push_back(poll_step(ok, raw));
    steps_sent++;
  endtask

  // One successful poll: select, trigger, address and read.
  task automatic poll_once(input logic [RAW_W-1:0] raw);
    send_step(1'($urandom_range(1)), 16'($urandom));
    send_step(1'b1, 16'($urandom));
    send_step(1'b1, 16'($urandom));
    send_step(1'b1, raw);
  endtask

  // Waits until every expected result has arrived and the block is quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Writes all six registers once the block is idle.
  task automatic apply_config(input ranger_cfg_t c);
    settle();
    write_reg(CFG_CAL_GAIN, CFG_W'(c.gain));
    write_reg(CFG_CAL_OFFSET, CFG_W'(c.offset));
    write_reg(CFG_RANGE_LOW, CFG_W'(c.lo_bound));
    write_reg(CFG_RANGE_HIGH, CFG_W'(c.hi_bound));
    write_reg(CFG_KEEP_WEIGHT, CFG_W'(c.keep));
    write_reg(CFG_TIMEOUT_LIMIT, CFG_W'(c.limit));
    cfg_we <= 1'b0;
    cfg_now = c;
    settings_applied++;
  endtask

  function automatic ranger_cfg_t random_setting();
    ranger_cfg_t c;
    c.gain = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                       : 16'($urandom_range(50000, 65535));
    c.offset = ($urandom_range(4) == 0) ? 20'hFFFFF : 20'($urandom_range(0, 20'hFFFFF));
    c.lo_bound = 16'($urandom_range(0, 40));
    c.hi_bound = ($urandom_range(5) == 0) ? 16'hFFFF : 16'($urandom_range(100, 2000));
    c.keep = ($urandom_range(5) == 0) ? 9'($urandom_range(257, 511))
                                       : 9'($urandom_range(0, 256));
    c.limit = ($urandom_range(5) == 0) ? 8'hFF : 8'($urandom_range(0, 10));
    return c;
  endfunction

  // Range words: mostly near the window so that updates happen, some anywhere.
  function automatic logic [RAW_W-1:0] pick_raw();
    int bound;
    bound = int'(cfg_now.hi_bound) + 40;
    if (bound > 65535) bound = 65535;
    case ($urandom_range(5))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      2:       return cfg_now.lo_bound + 16'($urandom_range(0, 2));
      default: return 16'($urandom_range(0, bound));
    endcase
  endfunction

  // Directed polls under the reset setting: every phase, failures in each phase,
  // a select with the bus flag low, readings inside and outside the window.
  task automatic test_directed_polls();
    send_step(1'b0, 16'h0000);
    send_step(1'b0, 16'hFFFF);
    send_step(1'b1, 16'h0000);
    send_step(1'b0, 16'hFFFF);
    send_step(1'b1, 16'h0000);
    send_step(1'b0, 16'hFFFF);
    send_step(1'b1, 16'd200);
    poll_once(16'd300);
    poll_once(16'h0000);
    poll_once(16'hFFFF);
    poll_once(16'd250);
  endtask

  // Timeouts in the trigger and read phases, and a successful read that meets
  // a timeout after the limit was lowered part way through a poll.
  task automatic test_timeouts();
    ranger_cfg_t c;
    c = cfg_now;
    c.limit = 8'd0;
    apply_config(c);
    send_step(1'b1, 16'd0);
    send_step(1'b0, 16'd0);
    send_step(1'b1, 16'd0);
    send_step(1'b1, 16'd0);
    send_step(1'b1, 16'd0);
    send_step(1'b0, 16'd0);
    c.limit = 8'd30;
    apply_config(c);
    send_step(1'b1, 16'd0);
    repeat (3) send_step(1'b0, 16'd0);
    send_step(1'b1, 16'd0);
    send_step(1'b1, 16'd0);
    c.limit = 8'd1;
    apply_config(c);
    send_step(1'b1, 16'd120);
  endtask

  // With the largest limit the failure count saturates instead of wrapping;
  // lowering the limit afterwards must then time out at once.
  task automatic test_count_saturation();
    ranger_cfg_t c;
    c = cfg_now;
    c.limit = 8'hFF;
    apply_config(c);
    send_step(1'b1, 16'd0);
    repeat (260) send_step(1'b0, 16'($urandom));
    c.limit = 8'd100;
    apply_config(c);
    send_step(1'b0, 16'd0);
  endtask

  // Extreme register settings, each with polls of both sensors.
  task automatic test_extreme_settings();
    ranger_cfg_t sweep [4];
    sweep[0] = '{16'hFFFF, 20'hFFFFF, 16'h0000, 16'hFFFF, 9'd0,   8'd0};
    sweep[1] = '{16'h0000, 20'h00000, 16'hFFFF, 16'h0000, 9'd511, 8'd255};
    sweep[2] = '{16'hFFFF, 20'h00000, 16'h0000, 16'hFFFF, 9'd256, 8'd254};
    sweep[3] = '{GAIN_RST, OFFSET_RST, LOW_RST, HIGH_RST, KEEP_RST, LIMIT_RST};
    foreach (sweep[i]) begin
      apply_config(sweep[i]);
      poll_once(16'h0000);
      poll_once(16'h0000);
      poll_once(16'hFFFF);
      poll_once(16'hFFFF);
      poll_once(16'($urandom_range(20, 480)));
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_backpressure();
    hold_asks <= hold_asks + 1;
    repeat (40) send_step($urandom_range(99) >= 10, pick_raw());
  endtask

  // Random polls under random settings; one round runs without any idling.
  task automatic test_random_polls();
    for (int round = 0; round < 5; round++) begin
      apply_config(random_setting());
      idle_on = (round != 2);
      repeat (20) send_step($urandom_range(99) >= 12, pick_raw());
    end
    idle_on = 1'b1;
  endtask

  initial begin
    cfg_now = '{GAIN_RST, OFFSET_RST, LOW_RST, HIGH_RST, KEEP_RST, LIMIT_RST};
    poll_phase = PH_SELECT;
    cur_sensor = 1'b0;
    fail_cnt = '0;
    enable_lines = '0;
    avg_dist[0] = '0;
    avg_dist[1] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_polls();
    test_timeouts();
    test_count_saturation();
    test_extreme_settings();
    test_backpressure();
    test_random_polls();

    settle();
    $display("Covered %0d poll steps under %0d register settings.", steps_sent,
             settings_applied);
    $display("Seen %0d distance updates and %0d timeouts; %0d mismatches.", updates_seen,
             timeouts_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Receiver: random stalls, and a long hold-off on request.
  always @(posedge clk) begin
    if (hold_asks != hold_taken) begin
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 18);
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_step = step_result_t'(m_tdata);
      if (expected_steps.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t ns: result with nothing expected, expected none, got %h", $time,
                   m_tdata);
      end else begin
        want_step = expected_steps.pop_front();
        check_field("action", 32'(want_step.action), 32'(got_step.action));
        check_field("sensor", 32'(want_step.sensor), 32'(got_step.sensor));
        check_field("enable_mask", 32'(want_step.enable_mask), 32'(got_step.enable_mask));
        check_field("updated", 32'(want_step.updated), 32'(got_step.updated));
        check_field("timed_out", 32'(want_step.timed_out), 32'(got_step.timed_out));
        check_field("distance", 32'(want_step.distance), 32'(got_step.distance));
        if (want_step.updated) updates_seen++;
        if (want_step.timed_out) timeouts_seen++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_cnt,
               expected_steps.size());
      $display("FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire
